@@ sv/sfd_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sfd_pkg
// Types and constants shared by the serial frame deframer modules.
// ---------------------------------------------------------------------------
package sfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned KindW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [ByteW-1:0] StartMarkerRst = 8'd170;
  localparam logic [ByteW-1:0] EndMarkerRst = 8'd85;
  localparam logic [ByteW-1:0] NoPayloadLen = 8'd2;
  localparam logic [ByteW-1:0] StrayBytes = 8'd1;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_MARKER = 1'b0,
    CFG_END_MARKER   = 1'b1
  } cfg_idx_e;

  typedef enum logic [KindW-1:0] {
    KIND_DATA    = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_BAD_CHK = 2'd2,
    KIND_BAD_END = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_LEN  = 3'd1,
    PH_SEQ  = 3'd2,
    PH_RESP = 3'd3,
    PH_DATA = 3'd4,
    PH_CHK  = 3'd5,
    PH_END  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] start_marker;
    logic [ByteW-1:0] end_marker;
  } cfg_t;

  typedef struct packed {
    kind_e            result_kind;
    logic [ByteW-1:0] data_byte;
    logic [ByteW-1:0] sequence_res;
    logic [ByteW-1:0] response_code;
    logic [ByteW-1:0] data_length;
  } result_t;

endpackage
`default_nettype wire

@@ sv/sfd_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sfd_rx_if / sfd_res_if
// Valid/ready channels for received bytes and for deframer results.
// ---------------------------------------------------------------------------
interface sfd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfd_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic [7:0] sequence_res;
  logic [7:0] response_code;
  logic [7:0] data_length;

  modport source (
    output valid, output result_kind, output data_byte, output sequence_res,
    output response_code, output data_length, input ready
  );
  modport sink (
    input valid, input result_kind, input data_byte, input sequence_res,
    input response_code, input data_length, output ready
  );
endinterface
`default_nettype wire

@@ sv/sfd_cfg_regs.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sfd_cfg_regs
// Start and end marker registers behind the plain write port.
// ---------------------------------------------------------------------------
module sfd_cfg_regs
  import sfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_START_MARKER: cfg_d.start_marker = cfg_data_i;
        CFG_END_MARKER:   cfg_d.end_marker = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_marker <= StartMarkerRst;
      cfg_q.end_marker <= EndMarkerRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

@@ sv/sfd_in_reg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sfd_in_reg
// Input register for received bytes; refills in the cycle it drains.
// ---------------------------------------------------------------------------
module sfd_in_reg
  import sfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  sfd_rx_if.sink                rx,
  input  wire logic             take_i,
  output logic                  valid_o,
  output logic [ByteW-1:0]      byte_o
);

  logic             valid_q, valid_d;
  logic [ByteW-1:0] byte_q;
  logic             load;

  assign rx.ready = !valid_q || take_i;
  assign load = rx.valid && rx.ready;
  assign valid_d = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= rx.rx_byte;
    end
  end

  assign valid_o = valid_q;
  assign byte_o = byte_q;

endmodule
`default_nettype wire

@@ sv/sfd_parser.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sfd_parser
// Frame state machine: checksum, length and held header bytes, and the
// results it emits for payload data bytes and at each frame's close.
// ---------------------------------------------------------------------------
module sfd_parser
  import sfd_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  cfg_t                  cfg_i,
  input  wire logic             step_i,
  input  wire logic [ByteW-1:0] byte_i,
  output logic                  emit_o,
  output result_t               result_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] chk_q, chk_d;
  logic [ByteW-1:0] len_q, len_d;
  logic [ByteW-1:0] taken_q, taken_d;
  logic [ByteW-1:0] seq_q, seq_d;
  logic [ByteW-1:0] resp_q, resp_d;
  logic [ByteW-1:0] payload_cnt;
  logic [ByteW-1:0] to_take;
  logic [ByteW-1:0] taken_inc;
  logic             emit;
  kind_e            kind;
  logic [ByteW-1:0] data;

  assign payload_cnt = (len_q > NoPayloadLen) ? (len_q - NoPayloadLen) : '0;
  assign to_take = (len_q < NoPayloadLen) ? StrayBytes : payload_cnt;
  assign taken_inc = taken_q + 8'd1;

  always_comb begin
    phase_d = phase_q;
    chk_d = chk_q;
    len_d = len_q;
    taken_d = taken_q;
    seq_d = seq_q;
    resp_d = resp_q;
    emit = 1'b0;
    kind = KIND_DATA;
    data = '0;
    unique case (phase_q)
      PH_LEN: begin
        len_d = byte_i;
        chk_d = byte_i;
        taken_d = '0;
        phase_d = PH_SEQ;
      end
      PH_SEQ: begin
        seq_d = byte_i;
        chk_d = chk_q ^ byte_i;
        phase_d = PH_RESP;
      end
      PH_RESP: begin
        resp_d = byte_i;
        chk_d = chk_q ^ byte_i;
        phase_d = (len_q == NoPayloadLen) ? PH_CHK : PH_DATA;
      end
      PH_DATA: begin
        chk_d = chk_q ^ byte_i;
        taken_d = taken_inc;
        if (taken_inc >= to_take) begin
          phase_d = PH_CHK;
        end
        if (len_q >= NoPayloadLen) begin
          emit = 1'b1;
          kind = KIND_DATA;
          data = byte_i;
        end
      end
      PH_CHK: begin
        if (byte_i == chk_q) begin
          phase_d = PH_END;
        end else begin
          phase_d = PH_WAIT;
          emit = 1'b1;
          kind = KIND_BAD_CHK;
        end
      end
      PH_END: begin
        phase_d = PH_WAIT;
        emit = 1'b1;
        kind = (byte_i == cfg_i.end_marker) ? KIND_GOOD : KIND_BAD_END;
      end
      default: begin
        if (byte_i == cfg_i.start_marker) begin
          taken_d = '0;
          seq_d = '0;
          phase_d = PH_LEN;
        end else begin
          phase_d = PH_WAIT;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      chk_q <= '0;
      len_q <= '0;
      taken_q <= '0;
      seq_q <= '0;
      resp_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      chk_q <= chk_d;
      len_q <= len_d;
      taken_q <= taken_d;
      seq_q <= seq_d;
      resp_q <= resp_d;
    end
  end

  assign emit_o = step_i && emit;
  assign result_o.result_kind = kind;
  assign result_o.data_byte = data;
  assign result_o.sequence_res = seq_q;
  assign result_o.response_code = resp_q;
  assign result_o.data_length = payload_cnt;

endmodule
`default_nettype wire

@@ sv/sfd_out_reg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sfd_out_reg
// Result register driving the result channel.
// ---------------------------------------------------------------------------
module sfd_out_reg
  import sfd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  result_t   result_i,
  output logic      free_o,
  sfd_res_if.source res
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign free_o = !valid_q || res.ready;
  assign valid_d = load_i || (valid_q && !res.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign res.valid = valid_q;
  assign res.result_kind = res_q.result_kind;
  assign res.data_byte = res_q.data_byte;
  assign res.sequence_res = res_q.sequence_res;
  assign res.response_code = res_q.response_code;
  assign res.data_length = res_q.data_length;

endmodule
`default_nettype wire

@@ sv/serial_frame_deframer.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// serial_frame_deframer
// Parses start/length/sequence/response/data/XOR checksum/end frames from a
// byte stream, passing data bytes through and closing each frame with a
// status beat.
// ---------------------------------------------------------------------------
//  channel  dir  beat contents
//  rx_i     in   rx_byte
//  res_o    out  result_kind, data_byte, sequence_res, response_code,
//                data_length
//  cfg      in   cfg_we_i, cfg_idx_i, cfg_data_i (write only)
//
// One byte per cycle sustained while results drain; a byte sits in the input
// register, and its result, if any, enters the result register when taken.
// The parser state advances when the input register's byte moves on, which
// needs the result register free or being drained.
// Reset restores the marker defaults and puts the parser in start hunting.
// A stalled result channel holds both registers; input flow resumes at once.
// ---------------------------------------------------------------------------
module serial_frame_deframer
  import sfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  sfd_rx_if.sink                  rx_i,
  sfd_res_if.source               res_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i
);

  cfg_t             cfg;
  logic             in_valid;
  logic [ByteW-1:0] in_byte;
  logic             out_free;
  logic             step;
  logic             emit;
  result_t          result;

  assign step = in_valid && out_free;

  sfd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  sfd_in_reg u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx      (rx_i),
    .take_i  (step),
    .valid_o (in_valid),
    .byte_o  (in_byte)
  );

  sfd_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .byte_i   (in_byte),
    .emit_o   (emit),
    .result_o (result)
  );

  sfd_out_reg u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (result),
    .free_o   (out_free),
    .res      (res_o)
  );

endmodule
`default_nettype wire

@@ tb/sfd_checker.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// sfd_checker
// Watches the byte and result channels of the serial frame deframer, tracks
// the frame parse on its own, and compares every result beat field by field.
// ---------------------------------------------------------------------------
module sfd_checker
  import sfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  sfd_rx_if                       rx_i,
  sfd_res_if                      res_i,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  output int unsigned             err_cnt_o,
  output int unsigned             pending_o
);

  cfg_t             markers;
  phase_e           phase;
  logic [ByteW-1:0] csum;
  logic [ByteW-1:0] flen;
  logic [ByteW-1:0] taken;
  logic [ByteW-1:0] seq_q;
  logic [ByteW-1:0] resp_q;
  result_t          frame_results_q[$];
  int unsigned      errs;

  function automatic logic [ByteW-1:0] payload_len(input logic [ByteW-1:0] len);
    return (len > NoPayloadLen) ? len - NoPayloadLen : '0;
  endfunction

  task automatic push_result(input kind_e kind, input logic [ByteW-1:0] data);
    result_t r;
    r.result_kind   = kind;
    r.data_byte     = data;
    r.sequence_res  = seq_q;
    r.response_code = resp_q;
    r.data_length   = payload_len(flen);
    frame_results_q.push_back(r);
  endtask

  task automatic parse_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] need;
    case (phase)
      PH_LEN: begin
        flen  = b;
        csum  = b;
        taken = '0;
        phase = PH_SEQ;
      end
      PH_SEQ: begin
        seq_q = b;
        csum  = csum ^ b;
        phase = PH_RESP;
      end
      PH_RESP: begin
        resp_q = b;
        csum   = csum ^ b;
        phase  = (flen == NoPayloadLen) ? PH_CHK : PH_DATA;
      end
      PH_DATA: begin
        csum  = csum ^ b;
        taken = taken + 1'b1;
        need  = (flen < NoPayloadLen) ? StrayBytes : payload_len(flen);
        if (taken >= need) phase = PH_CHK;
        if (flen >= NoPayloadLen) push_result(KIND_DATA, b);
      end
      PH_CHK: begin
        if (b == csum) begin
          phase = PH_END;
        end else begin
          phase = PH_WAIT;
          push_result(KIND_BAD_CHK, '0);
        end
      end
      PH_END: begin
        phase = PH_WAIT;
        push_result((b == markers.end_marker) ? KIND_GOOD : KIND_BAD_END, '0);
      end
      default: begin
        if (b == markers.start_marker) begin
          taken = '0;
          seq_q = '0;
          phase = PH_LEN;
        end else begin
          phase = PH_WAIT;
        end
      end
    endcase
  endtask

  function automatic void check_field(input string name, input logic [ByteW-1:0] want,
                                      input logic [ByteW-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      markers.start_marker = StartMarkerRst;
      markers.end_marker   = EndMarkerRst;
      phase  = PH_WAIT;
      csum   = '0;
      flen   = '0;
      taken  = '0;
      seq_q  = '0;
      resp_q = '0;
      errs   = 0;
      frame_results_q.delete();
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_START_MARKER) markers.start_marker = cfg_data_i;
        else if (cfg_idx_i == CFG_END_MARKER) markers.end_marker = cfg_data_i;
      end
      if (rx_i.valid && rx_i.ready) parse_byte(rx_i.rx_byte);
      if (res_i.valid && res_i.ready) begin
        if (frame_results_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d, data %0d",
                 res_i.result_kind, res_i.data_byte);
          errs++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("result_kind", ByteW'(want.result_kind), ByteW'(res_i.result_kind));
          check_field("data_byte", want.data_byte, res_i.data_byte);
          check_field("sequence_res", want.sequence_res, res_i.sequence_res);
          check_field("response_code", want.response_code, res_i.response_code);
          check_field("data_length", want.data_length, res_i.data_length);
        end
      end
      err_cnt_o <= errs;
      pending_o <= frame_results_q.size();
    end
  end

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tb
// Drives byte streams of well-formed, corrupted and cut frames into the
// serial frame deframer under several marker settings, with random stalls
// on both channels, and reports the checker's verdict.
// ---------------------------------------------------------------------------
module tb;
  import sfd_pkg::*;

  typedef logic [ByteW-1:0] byte_q_t[$];
  typedef enum int {FAULT_NONE, FAULT_CHK, FAULT_END, FAULT_CUT} fault_e;

  localparam int unsigned IdleLimit       = 2000;
  localparam int unsigned SettleCycles    = 8;
  localparam int unsigned ItemsPerSetting = 245;
  localparam int unsigned NumSettings     = 5;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [ByteW-1:0]   cfg_data;
  int unsigned        err_cnt;
  int unsigned        pending;

  logic [ByteW-1:0] cur_start = StartMarkerRst;
  logic [ByteW-1:0] cur_end = EndMarkerRst;
  int unsigned      bytes_sent = 0;
  int unsigned      frames_sent = 0;
  int unsigned      results_seen = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      ready_hold = 0;
  bit               quiet = 1'b0;

  sfd_rx_if  rx();
  sfd_res_if res();

  serial_frame_deframer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx),
    .res_o      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  sfd_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rx_i       (rx),
    .res_i      (res),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .err_cnt_o  (err_cnt),
    .pending_o  (pending)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    int unsigned r;
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        res.ready  <= 1'b1;
        ready_hold <= $urandom_range(0, 7);
      end else if (r < 55) begin
        res.ready  <= 1'b1;
        ready_hold <= $urandom_range(40, 150);
      end else if (r < 88) begin
        res.ready  <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        res.ready  <= 1'b0;
        ready_hold <= $urandom_range(8, 40);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((rx.valid && rx.ready) || (res.valid && res.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (res.valid && res.ready) results_seen <= results_seen + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) gap = 0;
    else if (r < 88) gap = $urandom_range(1, 3);
    else if (r < 97) gap = $urandom_range(4, 12);
    else gap = $urandom_range(20, 60);
    if (gap != 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx.valid   <= 1'b1;
    rx.rx_byte <= b;
    do @(posedge clk_i); while (!rx.ready);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [ByteW-1:0] len, input logic [ByteW-1:0] seq,
                            input logic [ByteW-1:0] resp, input byte_q_t data,
                            input fault_e fault);
    logic [ByteW-1:0] sum;
    int unsigned      n;
    sum = len ^ seq ^ resp;
    foreach (data[i]) sum = sum ^ data[i];
    n = (fault == FAULT_CUT) ? $urandom_range(0, data.size()) : data.size();
    send_byte(cur_start);
    send_byte(len);
    send_byte(seq);
    send_byte(resp);
    for (int i = 0; i < n; i++) send_byte(data[i]);
    if (fault != FAULT_CUT) begin
      if (fault == FAULT_CHK) begin
        send_byte(sum ^ ByteW'($urandom_range(1, 255)));
      end else begin
        send_byte(sum);
        send_byte((fault == FAULT_END) ? cur_end ^ ByteW'($urandom_range(1, 255)) : cur_end);
      end
    end
    frames_sent++;
  endtask

  task automatic random_frame(input logic [ByteW-1:0] len, input bit clean);
    byte_q_t     data;
    int unsigned n;
    int unsigned r;
    fault_e      fault;
    n = (len < NoPayloadLen) ? StrayBytes : len - NoPayloadLen;
    for (int i = 0; i < n; i++) data.push_back(ByteW'($urandom_range(0, 255)));
    r = $urandom_range(0, 99);
    if (clean || r < 80) fault = FAULT_NONE;
    else if (r < 88) fault = FAULT_CHK;
    else if (r < 95) fault = FAULT_END;
    else fault = FAULT_CUT;
    send_frame(len, ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)), data, fault);
  endtask

  function automatic logic [ByteW-1:0] pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return ByteW'($urandom_range(0, 1));
    if (r < 14) return NoPayloadLen;
    if (r < 98) return ByteW'($urandom_range(3, 12));
    return ByteW'($urandom_range(13, 40));
  endfunction

  task automatic send_noise();
    int unsigned      n;
    logic [ByteW-1:0] b;
    n = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 3);
    repeat (n) begin
      b = ByteW'($urandom_range(0, 255));
      if (b == cur_start && $urandom_range(0, 3) != 0) b = ~b;
      send_byte(b);
    end
  endtask

  task automatic drain();
    rx.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_markers(input logic [ByteW-1:0] s, input logic [ByteW-1:0] e);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_START_MARKER;
    cfg_data <= s;
    @(posedge clk_i);
    cfg_idx  <= CFG_END_MARKER;
    cfg_data <= e;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    cur_start = s;
    cur_end   = e;
  endtask

  initial begin
    byte_q_t          d;
    int unsigned      target;
    logic [ByteW-1:0] v;
    rx.valid   <= 1'b0;
    rx.rx_byte <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= CFG_START_MARKER;
    cfg_data   <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A start marker inside a frame is plain data here.
    send_byte(8'h00);
    send_byte(8'hFF);
    d.push_back(StartMarkerRst);
    send_frame(8'd3, 8'h00, 8'hFF, d, FAULT_NONE);
    d.delete();
    send_frame(NoPayloadLen, 8'h12, 8'h34, d, FAULT_END);
    d.push_back(8'h9A);
    send_frame(8'd0, 8'h56, 8'h78, d, FAULT_NONE);
    d.delete();
    d.push_back(8'h33);
    send_frame(8'd1, 8'h11, 8'h22, d, FAULT_CHK);
    drain();

    for (int s = 0; s < NumSettings; s++) begin
      case (s)
        1: set_markers(8'h00, 8'hFF);
        2: set_markers(8'hFF, 8'h00);
        3: set_markers(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
        4: begin
          v = ByteW'($urandom_range(0, 255));
          set_markers(v, v);
        end
        default: ;
      endcase
      target = bytes_sent + ItemsPerSetting;
      if (s == 2) random_frame(8'd255, 1'b1);
      while (bytes_sent < target) begin
        quiet = ($urandom_range(0, 99) < 15);
        send_noise();
        random_frame(pick_len(), 1'b0);
      end
      quiet = 1'b0;
      drain();
    end

    $display("Checked %0d result beats from %0d bytes in %0d frames over %0d marker settings,",
             results_seen, bytes_sent, frames_sent, NumSettings);
    $display("including corrupt and cut frames, stray-byte frames and one maximum-length frame.");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ filelist.f @@
sv/sfd_pkg.sv
sv/sfd_if.sv
sv/sfd_cfg_regs.sv
sv/sfd_in_reg.sv
sv/sfd_parser.sv
sv/sfd_out_reg.sv
sv/serial_frame_deframer.sv
tb/sfd_checker.sv
tb/tb.sv
